/* rtl/deq_pkg.sv */
// Package with shared constants, types, codes and ring index helpers of the deque.
package deq_pkg;

  localparam int DEPTH   = 1024;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 64;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 11;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_CLEAR      = 3'd4,
    MODE_QUERY      = 3'd5
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_FIN
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic need_read;
    logic out_free;
  } sts_t;

  function automatic idx_t idx_inc(idx_t idx);
    idx_t res;
    if (idx == IDX_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  function automatic idx_t idx_dec(idx_t idx);
    idx_t res;
    if (idx == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = idx - 1'b1;
    end
    return res;
  endfunction

  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* rtl/deq_if.sv */
// Request and result channel interfaces of the deque.
interface deq_req_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::MODE_W-1:0]        mode;
  logic signed [deq_pkg::VAL_W-1:0]  push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink (input valid, input mode, input push_value, output ready);
endinterface

interface deq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [deq_pkg::VAL_W-1:0]  popped_value;
  logic [deq_pkg::STAT_W-1:0]        status;
  logic signed [deq_pkg::VAL_W-1:0]  front_value;
  logic signed [deq_pkg::VAL_W-1:0]  back_value;
  logic [deq_pkg::COUNT_W-1:0]       item_count;

  modport source (output valid, output popped_value, output status, output front_value,
                  output back_value, output item_count, input ready);
  modport sink (input valid, input popped_value, input status, input front_value,
                input back_value, input item_count, output ready);
endinterface

/* rtl/deq_ctrl.sv */
// Controller state machine that sequences each deque request.
module deq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  deq_pkg::sts_t  sts_i,
  output deq_pkg::cmd_t  cmd_o
);

  deq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      deq_pkg::S_IDLE: begin
        if (req_valid_i) begin
          state_d = deq_pkg::S_EXEC;
        end
      end
      deq_pkg::S_EXEC: begin
        state_d = sts_i.need_read ? deq_pkg::S_LOAD : deq_pkg::S_FIN;
      end
      deq_pkg::S_LOAD: begin
        state_d = deq_pkg::S_FIN;
      end
      deq_pkg::S_FIN: begin
        if (sts_i.out_free) begin
          state_d = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = deq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o         = '0;
    case (state_q)
      deq_pkg::S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      deq_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      deq_pkg::S_LOAD: begin
        cmd_o.load = 1'b1;
      end
      deq_pkg::S_FIN: begin
        cmd_o.fin = sts_i.out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  a_load_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == deq_pkg::S_LOAD |-> $past(state_q) == deq_pkg::S_EXEC)
    else $error("Refetch state entered without an execute step.");

endmodule

/* rtl/deq_dp.sv */
// Datapath of the deque: ring store, pointers, cached end entries and result register.
module deq_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  deq_pkg::cmd_t          cmd_i,
  output deq_pkg::sts_t          sts_o,
  input  logic [deq_pkg::MODE_W-1:0] mode_i,
  input  deq_pkg::val_t          push_value_i,
  deq_rsp_if.source              rsp_o
);

  deq_pkg::val_t mem [deq_pkg::DEPTH];

  logic [deq_pkg::MODE_W-1:0] mode_q;
  deq_pkg::val_t              value_q;
  deq_pkg::idx_t              fi_q, fi_d;
  deq_pkg::cnt_t              cnt_q, cnt_d;
  deq_pkg::val_t              front_q, front_d;
  deq_pkg::val_t              back_q, back_d;
  deq_pkg::val_t              popped_q, popped_d;
  deq_pkg::status_e           stat_q, stat_d;
  logic                       rd_front_q, rd_front_d;
  deq_pkg::val_t              rdata_q;
  logic                       out_valid_q, out_valid_d;
  deq_pkg::val_t              out_popped_q, out_front_q, out_back_q;
  logic [deq_pkg::STAT_W-1:0] out_stat_q;
  logic [deq_pkg::COUNT_W-1:0] out_cnt_q;

  logic          wr_en, rd_en;
  deq_pkg::idx_t wr_addr, rd_addr;
  logic          full, empty, is_pop;

  assign full   = (cnt_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty  = (cnt_q == '0);
  assign is_pop = (mode_q == deq_pkg::MODE_POP_FRONT) || (mode_q == deq_pkg::MODE_POP_BACK);

  assign sts_o.need_read = is_pop && (cnt_q > deq_pkg::CNT_W'(1));
  assign sts_o.out_free  = !out_valid_q || rsp_o.ready;

  always_comb begin
    fi_d       = fi_q;
    cnt_d      = cnt_q;
    front_d    = front_q;
    back_d     = back_q;
    popped_d   = popped_q;
    stat_d     = stat_q;
    rd_front_d = rd_front_q;
    wr_en      = 1'b0;
    wr_addr    = fi_q;
    rd_en      = 1'b0;
    rd_addr    = fi_q;
    if (cmd_i.exec) begin
      popped_d = '0;
      stat_d   = deq_pkg::ST_OK;
      case (mode_q)
        deq_pkg::MODE_PUSH_FRONT: begin
          if (full) begin
            stat_d = deq_pkg::ST_FULL;
          end else begin
            fi_d    = deq_pkg::idx_dec(fi_q);
            wr_en   = 1'b1;
            wr_addr = deq_pkg::idx_dec(fi_q);
            cnt_d   = cnt_q + 1'b1;
            front_d = value_q;
            if (empty) begin
              back_d = value_q;
            end
          end
        end
        deq_pkg::MODE_PUSH_BACK: begin
          if (full) begin
            stat_d = deq_pkg::ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = deq_pkg::ring_add(fi_q, cnt_q);
            cnt_d   = cnt_q + 1'b1;
            back_d  = value_q;
            if (empty) begin
              front_d = value_q;
            end
          end
        end
        deq_pkg::MODE_POP_FRONT: begin
          if (empty) begin
            stat_d = deq_pkg::ST_EMPTY;
          end else begin
            popped_d   = front_q;
            fi_d       = deq_pkg::idx_inc(fi_q);
            cnt_d      = cnt_q - 1'b1;
            rd_en      = sts_o.need_read;
            rd_addr    = deq_pkg::idx_inc(fi_q);
            rd_front_d = 1'b1;
          end
        end
        deq_pkg::MODE_POP_BACK: begin
          if (empty) begin
            stat_d = deq_pkg::ST_EMPTY;
          end else begin
            popped_d   = back_q;
            cnt_d      = cnt_q - 1'b1;
            rd_en      = sts_o.need_read;
            rd_addr    = deq_pkg::ring_add(fi_q, cnt_q - deq_pkg::CNT_W'(2));
            rd_front_d = 1'b0;
          end
        end
        deq_pkg::MODE_CLEAR: begin
          fi_d  = '0;
          cnt_d = '0;
        end
        default: begin
          stat_d = deq_pkg::ST_OK;
        end
      endcase
    end
    if (cmd_i.load) begin
      if (rd_front_q) begin
        front_d = rdata_q;
      end else begin
        back_d = rdata_q;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.fin) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fi_q        <= fi_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q    <= front_d;
    back_q     <= back_d;
    popped_q   <= popped_d;
    stat_q     <= stat_d;
    rd_front_q <= rd_front_d;
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      value_q <= push_value_i;
    end
    if (cmd_i.fin) begin
      out_popped_q <= popped_q;
      out_stat_q   <= stat_q;
      out_front_q  <= empty ? '0 : front_q;
      out_back_q   <= empty ? '0 : back_q;
      out_cnt_q    <= deq_pkg::COUNT_W'(cnt_q);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.popped_value = out_popped_q;
  assign rsp_o.status       = out_stat_q;
  assign rsp_o.front_value  = out_front_q;
  assign rsp_o.back_value   = out_back_q;
  assign rsp_o.item_count   = out_cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("Entry count exceeds the ring depth.");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fi_q} < (deq_pkg::IDX_W + 1)'(deq_pkg::DEPTH))
    else $error("Front index lies outside the ring.");

  a_drop_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && full &&
    (mode_q == deq_pkg::MODE_PUSH_FRONT || mode_q == deq_pkg::MODE_PUSH_BACK)
    |=> cnt_q == $past(cnt_q) && fi_q == $past(fi_q))
    else $error("A dropped push changed the queue.");

endmodule

/* rtl/double_ended_queue.sv */
// Top level of the double-ended queue of signed 64-bit values over a ring store.
//
//   Channel  Direction  Transfer carries
//   req_i    in         mode, push_value
//   rsp_o    out        popped_value, status, front_value, back_value, item_count
//
// A request passes through capture, execute and finish steps; a pop that leaves the queue
// nonempty adds a refetch step before finish, reading its new end entry through the store's
// registered read port. One request is handled at a time; the next is taken while a result
// still waits in the output register. Reset clears the front index and count; the store
// itself is not cleared. A stalled result holds the sequencer in its last step.
module double_ended_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_req_if.sink    req_i,
  deq_rsp_if.source  rsp_o
);

  deq_pkg::cmd_t cmd;
  deq_pkg::sts_t sts;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  deq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (req_i.mode),
    .push_value_i (req_i.push_value),
    .rsp_o        (rsp_o)
  );

endmodule
